// ----- rtl/core/cffa_pkg.sv -----
package cffa_pkg;

  localparam int NumBlocksDef  = 64;
  localparam int MaxEntriesDef = 16;

  localparam logic [2:0] CmdCreate = 3'd0;
  localparam logic [2:0] CmdWrite  = 3'd1;
  localparam logic [2:0] CmdRead   = 3'd2;
  localparam logic [2:0] CmdSetLen = 3'd3;
  localparam logic [2:0] CmdDelete = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StDup      = 3'd2;
  localparam logic [2:0] StNoSpace  = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StRange    = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] file_key;
    logic [6:0]  length;
    logic [5:0]  offset;
    logic [7:0]  data_in;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] start_block;
    logic [6:0] extent_size;
    logic [7:0] data_out;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, clear result
    logic ent_clr;    // restart entry walk
    logic ent_step;   // look at next entry slot
    logic fit_clr;    // restart block scan
    logic fit_step;   // look at next block
    logic walk_init;  // set walk pointer for fill / clear
    logic walk_step;  // process one block of the walk
    logic byte_op;    // do a single byte access
    logic ent_alloc;  // record new entry
    logic ent_free;   // drop found entry
    logic set_status; // load status from code
    logic [2:0] code;
    logic finish_ok;  // copy start/size into result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic full;
    logic ent_done;   // walk of table finished
    logic found;
    logic fit_done;
    logic fit_ok;
    logic walk_done;
    logic range_bad;  // offset or growth out of range
  } sts_t;

endpackage

// ----- rtl/core/cffa_datapath.sv -----
module cffa_datapath #(
  parameter int NUM_BLOCKS  = cffa_pkg::NumBlocksDef,
  parameter int MAX_ENTRIES = cffa_pkg::MaxEntriesDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cffa_pkg::req_t req,
  input  cffa_pkg::ctl_t ctl,
  output cffa_pkg::sts_t sts,
  output cffa_pkg::rsp_t rsp
);
  localparam int BW = (NUM_BLOCKS  > 1) ? $clog2(NUM_BLOCKS)  : 1;
  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [NUM_BLOCKS-1:0]  used_r;
  logic [7:0]             byte_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]  bvalid_r;
  logic [MAX_ENTRIES-1:0] evalid_r;
  logic [15:0]            ekey_r   [MAX_ENTRIES];
  logic [BW-1:0]          estart_r [MAX_ENTRIES];
  logic [LW:0]            elen_r   [MAX_ENTRIES];
  logic [CW-1:0]          count_r;

  cffa_pkg::req_t req_r;
  cffa_pkg::rsp_t rsp_r;
  logic [EW:0]  eidx_r;
  logic [EW-1:0] slot_r, free_r;
  logic         found_r, free_ok_r;
  logic [BW:0]  bidx_r;
  logic [LW:0]  run_r;
  logic         fit_ok_r;
  logic [BW:0]  fstart_r;
  logic [LW:0]  st_r, sz_r;
  logic [LW:0]  wptr_r, wend_r;
  logic         wclr_used_r, wset_used_r;
  logic [7:0]   rd_q;

  logic [LW:0] len_x, off_x, run_inc, addr_x;
  logic        bad_len, zero_len;

  assign len_x    = (LW+1)'(req_r.length);
  assign off_x    = (LW+1)'(req_r.offset);
  assign run_inc  = run_r + 1'b1;
  assign addr_x   = st_r + off_x;
  assign bad_len  = len_x > (LW+1)'(NUM_BLOCKS);
  // a zero-length extent always fits at block 0
  assign zero_len = req_r.length == 7'd0;

  // status back to controller
  assign sts.cmd       = req_r.cmd;
  assign sts.full      = count_r >= CW'(MAX_ENTRIES);
  assign sts.ent_done  = eidx_r == (EW+1)'(MAX_ENTRIES);
  assign sts.found     = found_r;
  assign sts.fit_done  = fit_ok_r || zero_len || bidx_r == (BW+1)'(NUM_BLOCKS) || bad_len;
  assign sts.fit_ok    = fit_ok_r || zero_len;
  assign sts.walk_done = wptr_r >= wend_r;
  assign sts.range_bad = (req_r.cmd == cffa_pkg::CmdSetLen) ? (len_x > sz_r)
                                                            : (off_x >= sz_r);

  always_comb begin
    rsp = rsp_r;
    if (rsp_r.status == cffa_pkg::StOk && req_r.cmd == cffa_pkg::CmdRead)
      rsp.data_out = bvalid_r[addr_x[BW-1:0]] ? rd_q : 8'd0;
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      bvalid_r <= '0;
      evalid_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.walk_step && !sts.walk_done) begin
        if (wclr_used_r) used_r[wptr_r[BW-1:0]] <= 1'b0;
        if (wset_used_r) used_r[wptr_r[BW-1:0]] <= 1'b1;
        bvalid_r[wptr_r[BW-1:0]] <= 1'b0;
      end
      if (ctl.byte_op && req_r.cmd == cffa_pkg::CmdWrite)
        bvalid_r[addr_x[BW-1:0]] <= 1'b1;
      if (ctl.ent_alloc) begin
        evalid_r[free_r] <= 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (ctl.ent_free) begin
        evalid_r[slot_r] <= 1'b0;
        count_r <= count_r - 1'b1;
      end
    end
  end

  // byte store: a byte whose valid bit is clear reads as zero, so walks only drop valid bits
  always_ff @(posedge clk) begin
    if (ctl.byte_op && req_r.cmd == cffa_pkg::CmdWrite)
      byte_mem[addr_x[BW-1:0]] <= req_r.data_in;
    rd_q <= byte_mem[addr_x[BW-1:0]];
  end

  // entry table payload
  always_ff @(posedge clk) begin
    if (ctl.ent_alloc) begin
      ekey_r[free_r]   <= req_r.file_key;
      estart_r[free_r] <= fstart_r[BW-1:0];
      elen_r[free_r]   <= len_x;
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= req;
      rsp_r <= '0;
    end
    if (ctl.ent_clr) begin
      eidx_r <= '0; found_r <= 1'b0; free_ok_r <= 1'b0;
    end else if (ctl.ent_step && !sts.ent_done) begin
      if (evalid_r[eidx_r[EW-1:0]] && ekey_r[eidx_r[EW-1:0]] == req_r.file_key
          && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= eidx_r[EW-1:0];
        st_r    <= (LW+1)'(estart_r[eidx_r[EW-1:0]]);
        sz_r    <= elen_r[eidx_r[EW-1:0]];
      end
      if (!evalid_r[eidx_r[EW-1:0]] && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= eidx_r[EW-1:0];
      end
      eidx_r <= eidx_r + 1'b1;
    end
    if (ctl.fit_clr) begin
      bidx_r <= '0; run_r <= '0;
      fit_ok_r <= 1'b0;
      fstart_r <= '0;
    end else if (ctl.fit_step && !sts.fit_done) begin
      if (used_r[bidx_r[BW-1:0]]) run_r <= '0;
      else begin
        run_r <= run_inc;
        if (run_inc == len_x) begin
          fit_ok_r <= 1'b1;
          fstart_r <= bidx_r + 1'b1 - (BW+1)'(len_x);
        end
      end
      bidx_r <= bidx_r + 1'b1;
    end
    if (ctl.walk_init) begin
      wclr_used_r <= req_r.cmd == cffa_pkg::CmdDelete;
      wset_used_r <= req_r.cmd == cffa_pkg::CmdCreate;
      if (req_r.cmd == cffa_pkg::CmdCreate) begin
        wptr_r <= (LW+1)'(fstart_r); wend_r <= (LW+1)'(fstart_r) + len_x;
        st_r   <= (LW+1)'(fstart_r); sz_r   <= len_x;
      end else if (req_r.cmd == cffa_pkg::CmdSetLen) begin
        wptr_r <= st_r + len_x; wend_r <= st_r + sz_r;
      end else begin
        wptr_r <= st_r; wend_r <= st_r + sz_r;
      end
    end else if (ctl.walk_step && !sts.walk_done)
      wptr_r <= wptr_r + 1'b1;
    if (ctl.set_status) rsp_r.status <= ctl.code;
    if (ctl.finish_ok) begin
      rsp_r.start_block <= st_r[5:0];
      rsp_r.extent_size <= 7'(sz_r);
    end
  end
endmodule

// ----- rtl/core/cffa_ctrl.sv -----
module cffa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cffa_pkg::sts_t sts,
  output cffa_pkg::ctl_t ctl
);
  typedef enum logic [2:0] {
    S_IDLE, S_ENT, S_FIT, S_CHECK, S_WALK, S_BYTE, S_DONE
  } state_t;
  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // decode commands per state
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        ctl.load = in_valid;
        ctl.ent_clr = 1'b1;
        ctl.fit_clr = 1'b1;
      end
      S_ENT: ctl.ent_step = 1'b1;
      S_FIT: begin
        ctl.fit_step = 1'b1;
        ctl.ent_clr = 1'b0;
      end
      S_CHECK: begin
        ctl.walk_init = 1'b1;
        ctl.set_status = 1'b1;
        if (sts.cmd == cffa_pkg::CmdCreate) begin
          if (sts.full) ctl.code = cffa_pkg::StFull;
          else if (sts.found) ctl.code = cffa_pkg::StDup;
          else if (!sts.fit_ok) ctl.code = cffa_pkg::StNoSpace;
          else begin
            ctl.code = cffa_pkg::StOk; ctl.ent_alloc = 1'b1;
          end
        end else if (sts.cmd > cffa_pkg::CmdDelete) ctl.code = cffa_pkg::StRange;
        else if (!sts.found) ctl.code = cffa_pkg::StNotFound;
        else if (sts.cmd != cffa_pkg::CmdDelete && sts.range_bad)
          ctl.code = cffa_pkg::StRange;
        else begin
          ctl.code = cffa_pkg::StOk;
          ctl.ent_free = sts.cmd == cffa_pkg::CmdDelete;
        end
      end
      S_WALK: begin
        ctl.walk_step = 1'b1;
        ctl.finish_ok = sts.walk_done;
      end
      S_BYTE: begin
        ctl.byte_op = 1'b1;
        ctl.finish_ok = 1'b1;
      end
      default: ;
    endcase
  end

  // hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_ENT;
        S_ENT: if (sts.ent_done) state_r <= S_FIT;
        S_FIT: if (sts.fit_done) state_r <= S_CHECK;
        S_CHECK: begin
          if (ctl.code != cffa_pkg::StOk) begin
            state_r <= S_DONE; out_valid_r <= 1'b1;
          end else if (sts.cmd == cffa_pkg::CmdWrite || sts.cmd == cffa_pkg::CmdRead)
            state_r <= S_BYTE;
          else state_r <= S_WALK;
        end
        S_WALK: if (sts.walk_done) begin
          state_r <= S_DONE; out_valid_r <= 1'b1;
        end
        S_BYTE: begin
          state_r <= S_DONE; out_valid_r <= 1'b1;
        end
        S_DONE: if (out_ready) begin
          state_r <= S_IDLE; out_valid_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/contiguous_first_fit_allocator_top.sv -----
// First-fit contiguous extent store: 64 one-byte blocks and 16 keyed extents by default.
// One request is worked at a time. Each first walks the entry table, then runs the
// first-fit scan of the block map (the scan runs on the length field for every command and
// stops early on a fit, a zero length or an oversized length), then takes a decision, then
// walks the extent to mark, zero or free blocks, or does a single byte access; a failed
// request goes straight to its result. The result is held until taken.
module contiguous_first_fit_allocator_top #(
  parameter int NUM_BLOCKS  = cffa_pkg::NumBlocksDef,
  parameter int MAX_ENTRIES = cffa_pkg::MaxEntriesDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cffa_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cffa_pkg::rsp_t out_data
);
  cffa_pkg::ctl_t ctl;
  cffa_pkg::sts_t sts;

  cffa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .ctl
  );

  cffa_datapath #(.NUM_BLOCKS(NUM_BLOCKS), .MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk, .rst_n, .req(in_data), .ctl, .sts, .rsp(out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != cffa_pkg::StOk) |->
    (out_data.start_block == 6'd0 && out_data.extent_size == 7'd0))
    else $error("error result carries extent fields");
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
`endif
endmodule

// ----- dv/contiguous_first_fit_allocator_top_test.sv -----
module contiguous_first_fit_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = cffa_pkg::NumBlocksDef;
  localparam int NENT = cffa_pkg::MaxEntriesDef;
  localparam int RANDOM_REQS = 1850;
  localparam int STALL_LIMIT = 20000;

  // Extent store predictor plus queue of expected responses
  class extent_scoreboard;
    bit             used_map [NBLK];
    logic [7:0]     byte_map [NBLK];
    bit             ent_live [NENT];
    logic [15:0]    ent_key  [NENT];
    int             ent_start[NENT];
    int             ent_len  [NENT];
    int             ent_count;
    cffa_pkg::rsp_t pending[$];
    int             errors;

    function new();
      for (int b = 0; b < NBLK; b++) begin
        used_map[b] = 0;
        byte_map[b] = '0;
      end
      for (int s = 0; s < NENT; s++) begin
        ent_live[s] = 0;
        ent_key[s] = '0;
        ent_start[s] = 0;
        ent_len[s] = 0;
      end
      ent_count = 0;
      errors = 0;
    endfunction

    function int lookup(logic [15:0] key);
      for (int s = 0; s < NENT; s++)
        if (ent_live[s] && ent_key[s] == key) return s;
      return -1;
    endfunction

    function int first_fit(int len);
      int run;
      run = 0;
      if (len == 0) return 0;
      if (len > NBLK) return -1;
      for (int b = 0; b < NBLK; b++) begin
        run = used_map[b] ? 0 : run + 1;
        if (run == len) return b + 1 - len;
      end
      return -1;
    endfunction

    // Apply one accepted request and queue its response
    function void note_request(cffa_pkg::req_t r);
      cffa_pkg::rsp_t rsp;
      int   slot, pos, st, sz, s;
      rsp = '0;
      if (r.cmd == cffa_pkg::CmdCreate) begin
        if (ent_count >= NENT) rsp.status = cffa_pkg::StFull;
        else if (lookup(r.file_key) >= 0) rsp.status = cffa_pkg::StDup;
        else begin
          pos = first_fit(r.length);
          if (pos < 0) rsp.status = cffa_pkg::StNoSpace;
          else begin
            s = 0;
            while (s < NENT && ent_live[s]) s++;
            if (s >= NENT) rsp.status = cffa_pkg::StFull;
            else begin
              for (int i = 0; i < r.length; i++) begin
                used_map[pos + i] = 1;
                byte_map[pos + i] = '0;
              end
              ent_live[s] = 1;
              ent_key[s] = r.file_key;
              ent_start[s] = pos;
              ent_len[s] = r.length;
              ent_count++;
              rsp.start_block = pos[5:0];
              rsp.extent_size = r.length;
            end
          end
        end
      end else if (r.cmd <= cffa_pkg::CmdDelete) begin
        slot = lookup(r.file_key);
        if (slot < 0) rsp.status = cffa_pkg::StNotFound;
        else begin
          st = ent_start[slot];
          sz = ent_len[slot];
          if (r.cmd == cffa_pkg::CmdWrite || r.cmd == cffa_pkg::CmdRead) begin
            if (r.offset >= sz) rsp.status = cffa_pkg::StRange;
            else if (r.cmd == cffa_pkg::CmdWrite) byte_map[st + r.offset] = r.data_in;
            else rsp.data_out = byte_map[st + r.offset];
          end else if (r.cmd == cffa_pkg::CmdSetLen) begin
            if (r.length > sz) rsp.status = cffa_pkg::StRange;
            else for (int i = r.length; i < sz; i++) byte_map[st + i] = '0;
          end else begin
            for (int i = 0; i < sz; i++) begin
              byte_map[st + i] = '0;
              used_map[st + i] = 0;
            end
            ent_live[slot] = 0;
            if (ent_count > 0) ent_count--;
          end
          if (rsp.status == cffa_pkg::StOk) begin
            rsp.start_block = st[5:0];
            rsp.extent_size = sz[6:0];
          end
        end
      end else begin
        rsp.status = cffa_pkg::StRange;
      end
      pending.push_back(rsp);
    endfunction

    // Compare one response against the oldest expectation
    function void check_response(cffa_pkg::rsp_t got);
      cffa_pkg::rsp_t exp_rsp;
      if (pending.size() == 0) begin
        $error("unexpected response %h", got);
        errors++;
        return;
      end
      exp_rsp = pending.pop_front();
      if (got.status !== exp_rsp.status) begin
        $error("status: expected %0d actual %0d", exp_rsp.status, got.status);
        errors++;
      end
      if (got.start_block !== exp_rsp.start_block) begin
        $error("start_block: expected %0d actual %0d", exp_rsp.start_block, got.start_block);
        errors++;
      end
      if (got.extent_size !== exp_rsp.extent_size) begin
        $error("extent_size: expected %0d actual %0d", exp_rsp.extent_size, got.extent_size);
        errors++;
      end
      if (got.data_out !== exp_rsp.data_out) begin
        $error("data_out: expected %0d actual %0d", exp_rsp.data_out, got.data_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  cffa_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  cffa_pkg::rsp_t out_data;

  extent_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  send_done = 0;
  bit  hold_off = 0;
  int  burst_left = 0;
  // small pool of keys so lookups usually hit
  logic [15:0] key_pool[8] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
                               16'h00FF, 16'hAAAA, 16'h5555, 16'h7FFE};

  contiguous_first_fit_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Sample handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_response(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ready <= 0;
    else begin
      case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 9) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one request, wait until accepted, then either go on with the burst or pause
  task automatic send_request(cffa_pkg::req_t r);
    int gap;
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic cffa_pkg::req_t make_req(logic [2:0] cmd, logic [15:0] key,
                                              logic [6:0] len, logic [5:0] off,
                                              logic [7:0] din);
    cffa_pkg::req_t r;
    r.cmd = cmd;
    r.file_key = key;
    r.length = len;
    r.offset = off;
    r.data_in = din;
    return r;
  endfunction

  // Mostly well-formed commands on pooled keys, some noise
  function automatic cffa_pkg::req_t random_req();
    cffa_pkg::req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r.file_key = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 7)];
    r.offset = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    r.data_in = 8'($urandom);
    r.length = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 16));
    if (pick < 25) r.cmd = cffa_pkg::CmdCreate;
    else if (pick < 50) r.cmd = cffa_pkg::CmdWrite;
    else if (pick < 75) r.cmd = cffa_pkg::CmdRead;
    else if (pick < 83) r.cmd = cffa_pkg::CmdSetLen;
    else if (pick < 97) r.cmd = cffa_pkg::CmdDelete;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  initial begin
    int settle;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, every command, corner cases
    send_request(make_req(cffa_pkg::CmdCreate, 16'hFFFF, 7'd0, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdCreate, 16'hFFFF, 7'd4, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdCreate, 16'h0000, 7'd65, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdCreate, 16'h0000, 7'd127, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdCreate, 16'h0000, 7'd64, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdDelete, 16'h0000, 7'd0, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdCreate, 16'h0000, 7'd8, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdWrite, 16'h0000, 7'd0, 6'd7, 8'hFF));
    send_request(make_req(cffa_pkg::CmdWrite, 16'h0000, 7'd0, 6'd0, 8'hA5));
    send_request(make_req(cffa_pkg::CmdWrite, 16'h0000, 7'd0, 6'd8, 8'h5A));
    send_request(make_req(cffa_pkg::CmdWrite, 16'h0000, 7'd0, 6'd63, 8'h01));
    send_request(make_req(cffa_pkg::CmdRead, 16'h0000, 7'd0, 6'd7, 8'h00));
    send_request(make_req(cffa_pkg::CmdRead, 16'h0000, 7'd0, 6'd63, 8'h00));
    send_request(make_req(cffa_pkg::CmdRead, 16'h1234, 7'd0, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdSetLen, 16'h0000, 7'd9, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdSetLen, 16'h0000, 7'd8, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdSetLen, 16'h0000, 7'd1, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdRead, 16'h0000, 7'd0, 6'd7, 8'h00));
    send_request(make_req(cffa_pkg::CmdRead, 16'h0000, 7'd0, 6'd0, 8'h00));
    send_request(make_req(3'd5, 16'h0000, 7'd0, 6'd0, 8'h00));
    send_request(make_req(3'd7, 16'hFFFF, 7'd127, 6'd63, 8'hFF));
    // fill the table to reach the full-table case
    for (int k = 0; k < 16; k++)
      send_request(make_req(cffa_pkg::CmdCreate, 16'h4000 + 16'(k), 7'd1, 6'd0, 8'h00));
    for (int k = 0; k < 16; k++)
      send_request(make_req(cffa_pkg::CmdDelete, 16'h4000 + 16'(k), 7'd0, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdDelete, 16'h0000, 7'd0, 6'd0, 8'h00));
    send_request(make_req(cffa_pkg::CmdDelete, 16'hFFFF, 7'd0, 6'd0, 8'h00));

    // Random part, with one long receiver hold-off midway
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) begin
        fork
          begin
            hold_off = 1;
            repeat (2000) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_request(random_req());
    end
    in_valid <= 0;

    // Drain, then let the block settle
    while (sb.pending.size() != 0) @(negedge clk);
    settle = 0;
    while (settle < 200) begin
      @(negedge clk);
      settle++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
